FILE: rtl/glyph_mask_store_assert.svh
// Assertion macros for the glyph mask store.
// Each check runs on clk and is held off while arst_n is low.
`ifndef GLYPH_MASK_STORE_ASSERT_SVH
`define GLYPH_MASK_STORE_ASSERT_SVH

// Same-cycle implication.
`define GMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gms_pkg.sv
`timescale 1ns / 1ps
package gms_pkg;

	// Default store geometry
	localparam int DEF_MAX_GLYPHS = 128;
	localparam int DEF_MAX_CELL_W = 8;
	localparam int DEF_MAX_CELL_H = 8;

	// Field widths
	localparam int COORD_W    = 10;
	localparam int COLOUR_W   = 8;
	localparam int CODE_W     = 8;
	localparam int GPOS_W     = 3;
	localparam int CELL_OUT_W = 7;
	localparam int GRID_W     = 8;
	localparam int CSZ_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Cell count saturates at MAX_GLYPHS (128 by default); cell indices are 8 bits wide
	localparam int CNT_W  = 9;
	localparam int CELL_W = 8;

	// Divider operand widths
	localparam int DIV_NUM_W = COORD_W;
	localparam int DIV_DEN_W = GRID_W;

	// Luma weights, per mille
	localparam int LUMA_R   = 299;
	localparam int LUMA_G   = 587;
	localparam int LUMA_B   = 114;
	localparam int LUMA_DIV = 1000;
	localparam int INK_LUMA = 128;
	localparam int LUMA_W   = 18;
	localparam int INK_SUM  = INK_LUMA * LUMA_DIV;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd4;

	// Register reset values
	localparam logic [GRID_W-1:0] RST_GRID_COLUMNS = 8'd16;
	localparam logic [GRID_W-1:0] RST_GRID_ROWS    = 8'd6;
	localparam logic [CSZ_W-1:0]  RST_CELL_WIDTH   = 4'd8;
	localparam logic [CSZ_W-1:0]  RST_CELL_HEIGHT  = 4'd8;
	localparam logic [CODE_W-1:0] RST_FIRST_CODE   = 8'd32;

	// Opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		DIV_X,
		DIV_Y,
		DIV_C
	} div_sel_t;

	typedef enum logic [1:0] {
		OUT_ERR,
		OUT_LOAD,
		OUT_LOOK_ERR,
		OUT_LOOK
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     calc_count;
		logic     map_cell;
		logic     div_start;
		div_sel_t div_sel;
		logic     calc_rect;
		logic     take_cell;
		logic     mem_clr;
		logic     mem_wr;
		logic     mem_rd;
		logic     load_out;
		out_sel_t out_sel;
	} gms_cmd_t;

	typedef struct packed {
		logic cfg_ok;
		logic is_lookup;
		logic div_done;
		logic range_err;
		logic cell_err;
		logic glyph_err;
		logic clear_last;
	} gms_stat_t;

endpackage

FILE: rtl/gms_div.sv
`timescale 1ns / 1ps
module gms_div
	import gms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quotient,
	output logic [DIV_DEN_W-1:0] remainder
);

	localparam int CNT_BITS = $clog2(DIV_NUM_W + 1);

	logic [CNT_BITS-1:0]  cnt_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(DIV_NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_BITS'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/gms_dpath.sv
`timescale 1ns / 1ps
module gms_dpath
	import gms_pkg::*;
#(
	parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
	parameter int MAX_CELL_W = DEF_MAX_CELL_W,
	parameter int MAX_CELL_H = DEF_MAX_CELL_H
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gms_cmd_t              cmd,
	output gms_stat_t             stat,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  opcode,
	input  logic [COORD_W-1:0]    sheet_x,
	input  logic [COORD_W-1:0]    sheet_y,
	input  logic [COLOUR_W-1:0]   red,
	input  logic [COLOUR_W-1:0]   green,
	input  logic [COLOUR_W-1:0]   blue,
	input  logic [CODE_W-1:0]     char_code,
	input  logic [GPOS_W-1:0]     glyph_x,
	input  logic [GPOS_W-1:0]     glyph_y,
	output logic                  covered,
	output logic [CELL_OUT_W-1:0] cell_number,
	output logic [COORD_W-1:0]    rect_x,
	output logic [COORD_W-1:0]    rect_y,
	output logic [CSZ_W-1:0]      rect_w,
	output logic [CSZ_W-1:0]      rect_h,
	output logic                  error
);

	localparam int CELL_BITS = MAX_CELL_W * MAX_CELL_H;
	localparam int DEPTH     = MAX_GLYPHS * CELL_BITS;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W    = COORD_W + GRID_W;
	localparam int RECT_W    = COORD_W + CSZ_W;
	localparam logic [CSZ_W+1:0]     MAX_CW  = (CSZ_W + 2)'(MAX_CELL_W);
	localparam logic [CSZ_W+1:0]     MAX_CH  = (CSZ_W + 2)'(MAX_CELL_H);
	localparam logic [2*GRID_W-1:0]  MAX_G   = (2 * GRID_W)'(MAX_GLYPHS);

	// Configuration
	logic [GRID_W-1:0] cols_q;
	logic [GRID_W-1:0] rows_q;
	logic [CSZ_W-1:0]  cw_q;
	logic [CSZ_W-1:0]  ch_q;
	logic [CODE_W-1:0] fc_q;

	// Request
	logic               op_q;
	logic [COORD_W-1:0] sx_q;
	logic [COORD_W-1:0] sy_q;
	logic               ink_q;
	logic [CODE_W-1:0]  code_q;
	logic [GPOS_W-1:0]  gx_q;
	logic [GPOS_W-1:0]  gy_q;

	// Working registers
	logic [CNT_W-1:0]    count_q;
	logic [COORD_W-1:0]  col_q;
	logic [COORD_W-1:0]  row_q;
	logic [CSZ_W-1:0]    ox_q;
	logic [CSZ_W-1:0]    oy_q;
	logic [PROD_W:0]     cell_wide_q;
	logic [CELL_W-1:0]   cell_q;
	logic [COORD_W-1:0]  rx_q;
	logic [COORD_W-1:0]  ry_q;
	logic                rd_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                mask_mem_q [DEPTH];

	// Result register
	logic                  cov_q;
	logic [CELL_OUT_W-1:0] cell_out_q;
	logic [COORD_W-1:0]    rx_out_q;
	logic [COORD_W-1:0]    ry_out_q;
	logic [CSZ_W-1:0]      rw_out_q;
	logic [CSZ_W-1:0]      rh_out_q;
	logic                  err_out_q;

	logic [LUMA_W-1:0]    luma_sum;
	logic [2*GRID_W-1:0]  grid_prod;
	logic [CODE_W+1:0]    code_end;
	logic                 code_hit;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [DIV_DEN_W-1:0] div_rem;
	logic [PROD_W-1:0]    row_span;
	logic [RECT_W-1:0]    rx_prod;
	logic [RECT_W-1:0]    ry_prod;
	logic [CSZ_W-1:0]     off_x;
	logic [CSZ_W-1:0]     off_y;
	logic [31:0]          addr_wide;
	logic [ADDR_W-1:0]    addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= RST_GRID_COLUMNS;
			rows_q <= RST_GRID_ROWS;
			cw_q   <= RST_CELL_WIDTH;
			ch_q   <= RST_CELL_HEIGHT;
			fc_q   <= RST_FIRST_CODE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: cols_q <= cfg_data[GRID_W-1:0];
				REG_GRID_ROWS:    rows_q <= cfg_data[GRID_W-1:0];
				REG_CELL_WIDTH:   cw_q   <= cfg_data[CSZ_W-1:0];
				REG_CELL_HEIGHT:  ch_q   <= cfg_data[CSZ_W-1:0];
				REG_FIRST_CODE:   fc_q   <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Ink when integer luma reaches the threshold: compare the weighted sum instead
	assign luma_sum = LUMA_W'(red) * LUMA_W'(LUMA_R) + LUMA_W'(green) * LUMA_W'(LUMA_G)
		+ LUMA_W'(blue) * LUMA_W'(LUMA_B);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			sx_q   <= sheet_x;
			sy_q   <= sheet_y;
			ink_q  <= luma_sum >= LUMA_W'(INK_SUM);
			code_q <= char_code;
			gx_q   <= glyph_x;
			gy_q   <= glyph_y;
		end
	end

	assign grid_prod = cols_q * rows_q;

	always_ff @(posedge clk) begin
		if (cmd.calc_count) begin
			count_q <= (grid_prod > MAX_G) ? MAX_G[CNT_W-1:0] : grid_prod[CNT_W-1:0];
		end
	end

	// Codes outside the loaded range fall back to cell 0
	assign code_end = {2'b00, fc_q} + {1'b0, count_q};
	assign code_hit = (code_q >= fc_q) && ({2'b00, code_q} < code_end);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_X: begin
				div_num = sx_q;
				div_den = {{(DIV_DEN_W - CSZ_W){1'b0}}, cw_q};
			end
			DIV_Y: begin
				div_num = sy_q;
				div_den = {{(DIV_DEN_W - CSZ_W){1'b0}}, ch_q};
			end
			DIV_C: begin
				div_num = {{(DIV_NUM_W - CELL_W){1'b0}}, cell_q};
				div_den = cols_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	gms_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign row_span = row_q * cols_q;
	assign rx_prod  = col_q * cw_q;
	assign ry_prod  = row_q * ch_q;

	always_ff @(posedge clk) begin
		if (cmd.map_cell) begin
			cell_q <= code_hit ? (code_q - fc_q) : '0;
		end else if (cmd.take_cell) begin
			cell_q <= cell_wide_q[CELL_W-1:0];
		end
		if (div_done) begin
			unique case (cmd.div_sel)
				DIV_X: begin
					col_q <= div_quo;
					ox_q  <= div_rem[CSZ_W-1:0];
				end
				DIV_Y: begin
					row_q <= div_quo;
					oy_q  <= div_rem[CSZ_W-1:0];
				end
				DIV_C: begin
					col_q <= {{(COORD_W - DIV_DEN_W){1'b0}}, div_rem};
					row_q <= div_quo;
				end
				default: ;
			endcase
		end
		if (cmd.calc_rect) begin
			cell_wide_q <= {1'b0, row_span} + (PROD_W + 1)'(col_q);
			rx_q        <= rx_prod[COORD_W-1:0];
			ry_q        <= ry_prod[COORD_W-1:0];
		end
	end

	// Bit stride stays at the largest cell size
	assign off_x     = (op_q == OP_LOOKUP) ? {1'b0, gx_q} : ox_q;
	assign off_y     = (op_q == OP_LOOKUP) ? {1'b0, gy_q} : oy_q;
	assign addr_wide = 32'(cell_q) * 32'(CELL_BITS) + 32'(off_y) * 32'(MAX_CELL_W)
		+ 32'(off_x);
	assign addr      = addr_wide[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.mem_clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_clr) begin
			mask_mem_q[clr_cnt_q] <= 1'b0;
		end else if (cmd.mem_wr) begin
			mask_mem_q[addr] <= ink_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q <= mask_mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			unique case (cmd.out_sel)
				OUT_ERR: begin
					cov_q      <= 1'b0;
					cell_out_q <= '0;
					rx_out_q   <= '0;
					ry_out_q   <= '0;
					rw_out_q   <= '0;
					rh_out_q   <= '0;
					err_out_q  <= 1'b1;
				end
				OUT_LOAD, OUT_LOOK, OUT_LOOK_ERR: begin
					cov_q      <= (cmd.out_sel == OUT_LOAD) ? ink_q :
						(cmd.out_sel == OUT_LOOK) ? rd_q : 1'b0;
					cell_out_q <= cell_q[CELL_OUT_W-1:0];
					rx_out_q   <= rx_q;
					ry_out_q   <= ry_q;
					rw_out_q   <= cw_q;
					rh_out_q   <= ch_q;
					err_out_q  <= (cmd.out_sel == OUT_LOOK_ERR);
				end
				default: ;
			endcase
		end
	end

	assign covered     = cov_q;
	assign cell_number = cell_out_q;
	assign rect_x      = rx_out_q;
	assign rect_y      = ry_out_q;
	assign rect_w      = rw_out_q;
	assign rect_h      = rh_out_q;
	assign error       = err_out_q;

	assign stat.cfg_ok     = (cols_q != '0) && (rows_q != '0) && (cw_q != '0)
		&& ({2'b00, cw_q} <= MAX_CW) && (ch_q != '0) && ({2'b00, ch_q} <= MAX_CH);
	assign stat.is_lookup  = (op_q == OP_LOOKUP);
	assign stat.div_done   = div_done;
	assign stat.range_err  = (col_q >= {{(COORD_W - GRID_W){1'b0}}, cols_q})
		|| (row_q >= {{(COORD_W - GRID_W){1'b0}}, rows_q});
	assign stat.cell_err   = cell_wide_q >= (PROD_W + 1)'(count_q);
	assign stat.glyph_err  = ({1'b0, gx_q} >= cw_q) || ({1'b0, gy_q} >= ch_q);
	assign stat.clear_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

endmodule

FILE: rtl/gms_ctrl.sv
`timescale 1ns / 1ps
module gms_ctrl
	import gms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  gms_stat_t stat,
	output gms_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_MAP,
		S_DX_GO,
		S_DX_WAIT,
		S_DY_GO,
		S_DY_WAIT,
		S_DC_GO,
		S_DC_WAIT,
		S_RECT,
		S_CHK,
		S_WRITE,
		S_READ,
		S_FIN
	} state_t;

	state_t   state_q;
	out_sel_t sel_q;
	logic     out_valid_q;
	logic     out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sel_q       <= OUT_ERR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (!stat.cfg_ok) begin
						sel_q   <= OUT_ERR;
						state_q <= S_FIN;
					end else if (stat.is_lookup) begin
						state_q <= S_MAP;
					end else begin
						state_q <= S_DX_GO;
					end
				end
				S_MAP:     state_q <= S_DC_GO;
				S_DX_GO:   state_q <= S_DX_WAIT;
				S_DX_WAIT: begin
					if (stat.div_done) begin
						state_q <= S_DY_GO;
					end
				end
				S_DY_GO:   state_q <= S_DY_WAIT;
				S_DY_WAIT: begin
					if (stat.div_done) begin
						state_q <= S_RECT;
					end
				end
				S_DC_GO:   state_q <= S_DC_WAIT;
				S_DC_WAIT: begin
					if (stat.div_done) begin
						state_q <= S_RECT;
					end
				end
				S_RECT: begin
					if (stat.is_lookup) begin
						if (stat.glyph_err) begin
							sel_q   <= OUT_LOOK_ERR;
							state_q <= S_FIN;
						end else begin
							state_q <= S_READ;
						end
					end else if (stat.range_err) begin
						sel_q   <= OUT_ERR;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (stat.cell_err) begin
						sel_q   <= OUT_ERR;
						state_q <= S_FIN;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					sel_q   <= OUT_LOAD;
					state_q <= S_FIN;
				end
				S_READ: begin
					sel_q   <= OUT_LOOK;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.div_sel    = DIV_X;
		cmd.out_sel    = sel_q;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.calc_count = (state_q == S_PREP);
		cmd.map_cell   = (state_q == S_MAP);
		cmd.div_start  = (state_q == S_DX_GO) || (state_q == S_DY_GO)
			|| (state_q == S_DC_GO);
		if ((state_q == S_DY_GO) || (state_q == S_DY_WAIT)) begin
			cmd.div_sel = DIV_Y;
		end else if ((state_q == S_DC_GO) || (state_q == S_DC_WAIT)) begin
			cmd.div_sel = DIV_C;
		end
		cmd.calc_rect  = (state_q == S_RECT);
		cmd.take_cell  = (state_q == S_CHK);
		cmd.mem_clr    = (state_q == S_CLEAR);
		cmd.mem_wr     = (state_q == S_WRITE);
		cmd.mem_rd     = (state_q == S_READ);
		cmd.load_out   = (state_q == S_FIN) && out_free;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/glyph_mask_store.sv
// One request at a time; a new request is taken while the previous result still waits in the
// output register. The shared bit-serial divider sets the pace, with two passes for a load.
// Reset restores the register defaults, then a clearing pass zeroes all
// MAX_GLYPHS * MAX_CELL_W * MAX_CELL_H mask bits (8192 by default), taking no request.
`timescale 1ns / 1ps
`include "glyph_mask_store_assert.svh"
module glyph_mask_store
	import gms_pkg::*;
#(
	parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
	parameter int MAX_CELL_W = DEF_MAX_CELL_W,
	parameter int MAX_CELL_H = DEF_MAX_CELL_H
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [COORD_W-1:0]    sheet_x,
	input  logic [COORD_W-1:0]    sheet_y,
	input  logic [COLOUR_W-1:0]   red,
	input  logic [COLOUR_W-1:0]   green,
	input  logic [COLOUR_W-1:0]   blue,
	input  logic [CODE_W-1:0]     char_code,
	input  logic [GPOS_W-1:0]     glyph_x,
	input  logic [GPOS_W-1:0]     glyph_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  covered,
	output logic [CELL_OUT_W-1:0] cell_number,
	output logic [COORD_W-1:0]    rect_x,
	output logic [COORD_W-1:0]    rect_y,
	output logic [CSZ_W-1:0]      rect_w,
	output logic [CSZ_W-1:0]      rect_h,
	output logic                  error
);

	gms_cmd_t  cmd;
	gms_stat_t stat;
	logic [2:0] mem_ops;

	gms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gms_dpath #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.MAX_CELL_W (MAX_CELL_W),
		.MAX_CELL_H (MAX_CELL_H)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.sheet_x     (sheet_x),
		.sheet_y     (sheet_y),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.char_code   (char_code),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.covered     (covered),
		.cell_number (cell_number),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_w      (rect_w),
		.rect_h      (rect_h),
		.error       (error)
	);

	assign mem_ops = {cmd.mem_clr, cmd.mem_wr, cmd.mem_rd};

	`GMS_ASSERT_NOW(a_clear_blocks_req, cmd.mem_clr, !in_ready, "request taken during clear")
	`GMS_ASSERT_NOW(a_one_mem_op, 1'b1, $onehot0(mem_ops), "two store operations at once")
	`GMS_ASSERT_NOW(a_out_free, cmd.load_out, !out_valid || out_ready, "result overwritten")
	`GMS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken")

endmodule
